FILE: design/wld_pkg.sv
// Package: shared widths, the pixel record and the front-to-back command record.
package wld_pkg;
  localparam int MaxPixels = 64;
  localparam int IdxW = 6;
  localparam int CntW = 7;
  localparam int FieldW = 24;

  typedef struct packed {
    logic [FieldW-1:0] lam;
    logic signed [FieldW-1:0] dlt;
    logic [FieldW-1:0] wgt;
    logic signed [FieldW-1:0] cor;
  } pix_t;

  // Command from the loader to the solver: one per completed run.
  typedef struct packed {
    logic [CntW-1:0] count;
    logic [29:0] sw;
    logic [53:0] swl;
    logic signed [53:0] swd;
  } run_cmd_t;
endpackage

FILE: design/wld_stream_if.sv
// Interfaces: input pixel channel and result channel.
interface wld_in_if;
  logic valid;
  logic ready;
  logic [23:0] log_wavelength;
  logic signed [23:0] delta_value;
  logic [23:0] pixel_weight;
  logic signed [23:0] correction;
  logic last_in;
  modport source(output valid, log_wavelength, delta_value, pixel_weight, correction,
    last_in, input ready);
  modport sink(input valid, log_wavelength, delta_value, pixel_weight, correction,
    last_in, output ready);
endinterface

interface wld_out_if;
  logic valid;
  logic ready;
  logic signed [23:0] detrended_delta;
  logic [5:0] pixel_index;
  logic no_weight;
  logic no_spread;
  logic last_out;
  modport source(output valid, detrended_delta, pixel_index, no_weight, no_spread,
    last_out, input ready);
  modport sink(input valid, detrended_delta, pixel_index, no_weight, no_spread,
    last_out, output ready);
endinterface

FILE: design/weighted_linear_detrend_unit.sv
// Input: one pixel per cycle while the store is free; none while a run is being solved.
// After the last pixel: two mean divides (only with nonzero total weight), a spread walk
// over the stored pixels, then for each result a trend divide when its trend is nonzero,
// each done by the 128-step serial divider; output stalls hold the output walk. One run at a time.
// Reset: synchronous rst clears counts, sums, state and skip_correction; store is
// unreset and only written entries are read.
module weighted_linear_detrend_unit
  import wld_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_wdata,
  wld_in_if.sink  in_ch,
  wld_out_if.source out_ch
);
  logic skip_correction;
  logic wr_en, store_free, cmd_valid;
  logic [IdxW-1:0] wr_addr, rd_addr;
  pix_t wr_data, rd_data;
  run_cmd_t cmd;
  pix_t mem [MaxPixels];

  always_ff @(posedge clk) begin
    if (rst) skip_correction <= 1'b0;
    else if (cfg_we) skip_correction <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  wld_loader u_load (.clk, .rst, .px(in_ch), .wr_en, .wr_addr, .wr_data, .store_free,
    .cmd_valid, .cmd);
  wld_solver u_solve (.clk, .rst, .skip_correction, .cmd_valid, .cmd, .store_free,
    .rd_addr, .rd_data, .res(out_ch));

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    !store_free |-> !wr_en) else $error("store written while busy");
  a_cmd_pulse: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |=> !cmd_valid) else $error("run command repeated");
endmodule

FILE: design/wld_divider.sv
// Divider: restoring unsigned divide, one quotient bit per cycle, rounded, limited.
module wld_divider
  import wld_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] num,
  input  logic [63:0]  den,
  output logic         done,
  output logic [63:0]  quo
);
  logic [127:0] n;
  logic [64:0] r;
  logic [63:0] q;
  logic big;
  logic [7:0] cnt;
  logic busy;
  logic fin;
  logic [64:0] r_sh;
  logic [64:0] r_sub;
  logic [63:0] q_rnd;

  assign r_sh = {r[63:0], n[127]};
  assign r_sub = r_sh - {1'b0, den};
  // Round half up: remainder >= den - remainder
  assign q_rnd = q + 64'(({r[63:0], 1'b0} >= {1'b0, den}) ? 1 : 0);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      fin <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      fin <= 1'b0;
      n <= num;
      r <= '0;
      q <= '0;
      big <= 1'b0;
      cnt <= 8'd127;
    end else if (busy) begin
      n <= {n[126:0], 1'b0};
      if (q[63:62] != 2'b00) big <= 1'b1;
      if (!r_sub[64]) begin
        r <= r_sub;
        q <= {q[62:0], 1'b1};
      end else begin
        r <= r_sh;
        q <= {q[62:0], 1'b0};
      end
      if (cnt == 8'd0) begin
        busy <= 1'b0;
        fin <= 1'b1;
      end
      cnt <= cnt - 8'd1;
    end else if (fin) begin
      fin <= 1'b0;
      done <= 1'b1;
      quo <= (big || q_rnd > 64'h100_0000_0000) ? 64'h100_0000_0000 : q_rnd;
    end
  end
endmodule

FILE: design/wld_loader.sv
// Front end: takes pixels, writes the store, accumulates weighted sums, queues runs.
module wld_loader
  import wld_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  wld_in_if.sink      px,
  output logic        wr_en,
  output logic [IdxW-1:0] wr_addr,
  output pix_t        wr_data,
  input  logic        store_free,
  output logic        cmd_valid,
  output run_cmd_t    cmd
);
  logic [CntW-1:0] count;
  logic [29:0] sw;
  logic [53:0] swl;
  logic signed [53:0] swd;
  logic room;
  logic acc;

  // Pixels may load only while the back end does not own the store.
  assign px.ready = store_free && !cmd_valid;
  assign acc = px.valid && px.ready;
  assign room = count < CntW'(MaxPixels);
  assign wr_en = acc && room;
  assign wr_addr = count[IdxW-1:0];
  assign wr_data = '{lam: px.log_wavelength, dlt: px.delta_value,
    wgt: px.pixel_weight, cor: px.correction};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sw <= '0;
      swl <= '0;
      swd <= '0;
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= 1'b0;
      if (acc) begin
        if (px.last_in) begin
          cmd_valid <= 1'b1;
          cmd.count <= count + CntW'(room);
          cmd.sw <= sw + (room ? 30'(px.pixel_weight) : 30'd0);
          cmd.swl <= swl + (room ? 54'(px.pixel_weight) * 54'(px.log_wavelength) : 54'd0);
          cmd.swd <= swd + (room ? 54'($signed({1'b0, px.pixel_weight})) * 54'(px.delta_value)
            : 54'sd0);
          count <= '0;
          sw <= '0;
          swl <= '0;
          swd <= '0;
        end else if (room) begin
          count <= count + CntW'(1);
          sw <= sw + 30'(px.pixel_weight);
          swl <= swl + 54'(px.pixel_weight) * 54'(px.log_wavelength);
          swd <= swd + 54'($signed({1'b0, px.pixel_weight})) * 54'(px.delta_value);
        end
      end
    end
  end
endmodule

FILE: design/wld_solver.sv
// Back end: means, spread/covariance walk, and output walk over the pixel store.
module wld_solver
  import wld_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        skip_correction,
  input  logic        cmd_valid,
  input  run_cmd_t    cmd,
  output logic        store_free,
  output logic [IdxW-1:0] rd_addr,
  input  pix_t        rd_data,
  wld_out_if.source   res
);
  typedef enum logic [3:0] {
    S_IDLE, S_ML, S_MD, S_MDW, S_SREAD, S_SMUL, S_SACC, S_OREAD, S_OMUL, S_OPLO, S_OPHI,
    S_ODIV, S_OUT
  } state_t;
  state_t state;

  run_cmd_t c;
  logic [CntW-1:0] idx;
  logic no_w, no_s;
  logic signed [25:0] ml;
  logic signed [25:0] md;
  logic [63:0] spread;
  logic signed [63:0] cov;
  logic signed [25:0] dl;
  logic [24:0] adl;
  logic [49:0] sq;
  logic signed [49:0] dd;
  logic [63:0] acov;
  logic [127:0] prod;
  logic [56:0] pp;
  logic neg_trend;

  logic div_start, div_done;
  logic [127:0] div_num;
  logic [63:0] div_den, div_q;
  logic [53:0] amag;

  wld_divider u_div (.clk, .rst, .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q));

  assign store_free = (state == S_IDLE);
  assign rd_addr = idx[IdxW-1:0];
  assign amag = c.swd[53] ? 54'(-c.swd) : 54'(c.swd);

  // |cov| * |dl| in two 32x25 halves: low half, then high half
  assign pp = {25'b0, (state == S_OPLO) ? acov[31:0] : acov[63:32]} * {32'b0, adl};

  logic signed [25:0] dl_c;
  assign dl_c = $signed({2'b00, rd_data.lam}) - ml;

  logic signed [63:0] trend;
  logic signed [63:0] v;
  always_comb begin
    trend = neg_trend ? -$signed(div_q) : $signed(div_q);
    if (no_s || cov == 0 || dl == 0) trend = '0;
    v = 64'(rd_data.dlt) - 64'(md) - trend - (skip_correction ? 64'sd0 : 64'(rd_data.cor));
  end

  always_ff @(posedge clk) begin
    div_start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      res.valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (cmd_valid) begin
          c <= cmd;
          no_w <= (cmd.sw == 0);
          ml <= '0;
          md <= '0;
          if (cmd.sw != 0) begin
            div_start <= 1'b1;
            div_num <= 128'(cmd.swl);
            div_den <= 64'(cmd.sw);
            state <= S_ML;
          end else begin
            state <= S_SREAD;
          end
          idx <= '0;
          spread <= '0;
          cov <= '0;
        end
        S_ML: if (div_done) begin
          ml <= 26'(div_q);
          div_start <= 1'b1;
          div_num <= 128'(amag);
          state <= S_MD;
        end
        S_MD: if (div_done) begin
          md <= c.swd[53] ? -26'(div_q) : 26'(div_q);
          state <= S_SREAD;
        end
        S_SREAD: begin
          // store read is registered; data valid next cycle
          if (idx == c.count) begin
            no_s <= (spread == 0);
            idx <= '0;
            state <= S_OREAD;
          end else state <= S_SMUL;
        end
        S_SMUL: begin
          dl <= dl_c;
          adl <= dl_c[25] ? 25'(-dl_c) : 25'(dl_c);
          state <= S_SACC;
        end
        S_SACC: begin
          sq <= (50'(adl) * 50'(adl)) >> 16;
          dd <= (50'(rd_data.dlt) * 50'(dl)) >>> 16;
          state <= S_MDW;
        end
        S_MDW: begin
          spread <= spread + 64'(rd_data.wgt) * 64'(sq);
          cov <= cov + $signed({1'b0, 40'(rd_data.wgt)}) * 64'(dd);
          idx <= idx + CntW'(1);
          state <= S_SREAD;
        end
        S_OREAD: begin
          acov <= cov[63] ? 64'(-cov) : 64'(cov);
          state <= S_OMUL;
        end
        S_OMUL: begin
          dl <= dl_c;
          adl <= dl_c[25] ? 25'(-dl_c) : 25'(dl_c);
          neg_trend <= cov[63] != dl_c[25];
          state <= S_OPLO;
        end
        S_OPLO: begin
          prod <= {71'b0, pp};
          state <= S_OPHI;
        end
        S_OPHI: begin
          if (!no_s && cov != 0 && dl != 0) begin
            div_start <= 1'b1;
            div_num <= prod + {39'b0, pp, 32'b0};
            div_den <= spread;
            state <= S_ODIV;
          end else state <= S_OUT;
        end
        S_ODIV: if (div_done) state <= S_OUT;
        S_OUT: if (!res.valid || res.ready) begin
          res.valid <= 1'b1;
          res.detrended_delta <= (v > 64'sd8388607) ? 24'sh7fffff :
            (v < -64'sd8388608) ? 24'sh800000 : 24'(v);
          res.pixel_index <= idx[IdxW-1:0];
          res.no_weight <= no_w;
          res.no_spread <= no_s;
          res.last_out <= (idx + CntW'(1) == c.count);
          idx <= idx + CntW'(1);
          state <= (idx + CntW'(1) == c.count) ? S_IDLE : S_OREAD;
        end
        default: state <= S_IDLE;
      endcase
      if (res.valid && res.ready && !(state == S_OUT)) res.valid <= 1'b0;
    end
  end
endmodule

FILE: tb/sv/tb_top.sv
// Testbench for weighted_linear_detrend_unit: random and directed spectra checked by a scoreboard.
`timescale 1ns / 1ps

module tb_top
  import wld_pkg::*;
;

  typedef struct packed {
    logic signed [23:0] detrended_delta;
    logic [5:0] pixel_index;
    logic no_weight;
    logic no_spread;
    logic last_out;
  } detrended_t;

  class detrend_scoreboard;
    pix_t spectrum[MaxPixels];
    int unsigned n_pix;
    logic [63:0] sum_w;
    logic [63:0] sum_wl;
    longint sum_wd;
    bit skip_cor;
    detrended_t expected_q[$];
    int mismatches;

    function new();
      n_pix = 0;
      sum_w = 0;
      sum_wl = 0;
      sum_wd = 0;
      skip_cor = 0;
      mismatches = 0;
    endfunction

    function logic [63:0] rdiv(logic [63:0] n, logic [63:0] d);
      logic [63:0] q;
      logic [63:0] r;
      q = n / d;
      r = n % d;
      if (r >= d - r) q++;
      return q;
    endfunction

    function void note_pixel(pix_t p, bit last);
      longint ml;
      longint md;
      longint dl;
      longint tr;
      longint v;
      longint w;
      longint d;
      logic [63:0] adl;
      logic [63:0] ac;
      logic [63:0] spread;
      longint cov;
      logic [127:0] prod;
      logic [127:0] q;
      logic [127:0] r;
      bit nw;
      bit ns;
      detrended_t e;
      if (n_pix < MaxPixels) begin
        spectrum[n_pix] = p;
        n_pix++;
        sum_w += 64'(p.wgt);
        sum_wl += 64'(p.wgt) * 64'(p.lam);
        sum_wd += longint'({40'b0, p.wgt}) * longint'(p.dlt);
      end
      if (!last) return;
      ml = 0;
      md = 0;
      nw = (sum_w == 0);
      if (!nw) begin
        ml = longint'(rdiv(sum_wl, sum_w));
        if (sum_wd >= 0) md = longint'(rdiv(64'(sum_wd), sum_w));
        else md = -longint'(rdiv(64'(-sum_wd), sum_w));
      end
      spread = 0;
      cov = 0;
      for (int i = 0; i < n_pix; i++) begin
        dl = longint'({40'b0, spectrum[i].lam}) - ml;
        adl = 64'(dl < 0 ? -dl : dl);
        w = longint'({40'b0, spectrum[i].wgt});
        d = longint'(spectrum[i].dlt);
        spread += 64'(w) * ((adl * adl) >> 16);
        cov += w * ((d * dl) >>> 16);
      end
      ns = (spread == 0);
      for (int i = 0; i < n_pix; i++) begin
        dl = longint'({40'b0, spectrum[i].lam}) - ml;
        tr = 0;
        if (!ns && cov != 0 && dl != 0) begin
          ac = 64'(cov < 0 ? -cov : cov);
          adl = 64'(dl < 0 ? -dl : dl);
          prod = {64'b0, ac} * {64'b0, adl};
          q = prod / {64'b0, spread};
          r = prod % {64'b0, spread};
          if (r >= {64'b0, spread} - r) q++;
          if (q > (128'd1 << 40)) q = 128'd1 << 40;
          tr = ((cov < 0) != (dl < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
        end
        v = longint'(spectrum[i].dlt) - md - tr;
        if (!skip_cor) v -= longint'(spectrum[i].cor);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        e.detrended_delta = v[23:0];
        e.pixel_index = i[5:0];
        e.no_weight = nw;
        e.no_spread = ns;
        e.last_out = (i + 1 == n_pix);
        expected_q = {expected_q, e};
      end
      n_pix = 0;
      sum_w = 0;
      sum_wl = 0;
      sum_wd = 0;
    endfunction

    function void check_result(detrended_t got);
      detrended_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      e = expected_q.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp val=%0d idx=%0d nw=%b ns=%b last=%b",
                   e.detrended_delta, e.pixel_index, e.no_weight, e.no_spread, e.last_out);
          $display("          got val=%0d idx=%0d nw=%b ns=%b last=%b",
                   got.detrended_delta, got.pixel_index, got.no_weight, got.no_spread,
                   got.last_out);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_wdata = 0;
  bit quiet = 0;

  wld_in_if in_ch();
  wld_out_if out_ch();

  detrend_scoreboard sb = new();

  always #6 clk = ~clk;

  weighted_linear_detrend_unit u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  initial begin
    in_ch.valid = 0;
    in_ch.log_wavelength = 0;
    in_ch.delta_value = 0;
    in_ch.pixel_weight = 0;
    in_ch.correction = 0;
    in_ch.last_in = 0;
    out_ch.ready = 0;
  end

  // Receiver: random stall bursts, none once quiet is set.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready)
        sb.check_result({out_ch.detrended_delta, out_ch.pixel_index, out_ch.no_weight,
                         out_ch.no_spread, out_ch.last_out});
      if (stall > 0) stall--;
      else if (!quiet && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 18);
      out_ch.ready <= (stall == 0);
    end
  end

  task automatic send_pixel(pix_t p, bit last);
    int gap;
    in_ch.valid <= 1;
    in_ch.log_wavelength <= p.lam;
    in_ch.delta_value <= p.dlt;
    in_ch.pixel_weight <= p.wgt;
    in_ch.correction <= p.cor;
    in_ch.last_in <= last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_pixel(p, last);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_skip(bit v);
    drain_results();
    in_ch.valid <= 0;
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.skip_cor = v;
  endtask

  function automatic pix_t rand_pixel(logic [23:0] centre, int unsigned span);
    pix_t p;
    p.lam = centre + 24'($urandom_range(0, span));
    p.dlt = 24'($urandom);
    p.wgt = ($urandom_range(0, 9) == 0) ? 24'd0 : 24'($urandom);
    p.cor = 24'($urandom);
    if ($urandom_range(0, 3) == 0) p.wgt = 24'($urandom_range(0, 65536 * 4));
    return p;
  endfunction

  task automatic send_run(int len, logic [23:0] centre, int unsigned span);
    for (int i = 0; i < len; i++) send_pixel(rand_pixel(centre, span), i == len - 1);
  endtask

  initial begin
    pix_t p;
    int len;
    int sent;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    set_skip(0);
    // single pixel of extremes: spread is zero
    send_pixel('{lam: 24'hFFFFFF, dlt: 24'sh7FFFFF, wgt: 24'hFFFFFF, cor: 24'sh800000}, 1);
    // zero total weight
    send_pixel('{lam: 24'h000000, dlt: 24'sh800000, wgt: 24'h0, cor: 24'sh7FFFFF}, 0);
    send_pixel('{lam: 24'hFFFFFF, dlt: 24'sh7FFFFF, wgt: 24'h0, cor: 24'sh000001}, 1);
    // same wavelength everywhere: zero spread with weight
    send_pixel('{lam: 24'h400000, dlt: 24'sh010000, wgt: 24'h010000, cor: 24'sh0}, 0);
    send_pixel('{lam: 24'h400000, dlt: -24'sh020000, wgt: 24'h020000, cor: 24'sh0}, 1);
    // two far-apart pixels with extreme deltas: steep trend, saturation
    send_pixel('{lam: 24'h000000, dlt: 24'sh800000, wgt: 24'hFFFFFF, cor: 24'sh7FFFFF}, 0);
    send_pixel('{lam: 24'hFFFFFF, dlt: 24'sh7FFFFF, wgt: 24'hFFFFFF, cor: 24'sh800000}, 1);
    set_skip(1);
    send_run(3, 24'h300000, 4000);
    // overfull spectrum: pixel beyond the store is dropped, its last still ends the run
    send_run(MaxPixels + 1, 24'h200000, 1 << 20);
    drain_results();  // sender holds off until every result is in
    set_skip(0);

    sent = 0;
    while (sent < 40) begin
      if (sent > 28) quiet = 1;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, MaxPixels) : $urandom_range(1, 8);
      if ($urandom_range(0, 4) == 0) send_run(len, 24'($urandom), 24'hFFFFFF);
      else send_run(len, 24'($urandom_range(0, 24'hF00000)), $urandom_range(1, 1 << 16));
      sent += len;
      if ($urandom_range(0, 3) == 0) set_skip(1'($urandom_range(0, 1)));
    end
    quiet = 1;
    set_skip(1);
    send_run(4, 24'h100000, 1000);

    drain_results();
    repeat (300) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end
endmodule
